[rtl/pas_pkg.sv]
package pas_pkg;

   localparam int NumSourcesDefault = 64;

   typedef enum logic [1:0] {
      FUNC_TICK    = 2'd0,
      FUNC_REQUEST = 2'd1,
      FUNC_LOAD    = 2'd2,
      FUNC_UNUSED  = 2'd3
   } func_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_OPEN_CHK,
      ST_OPEN_WR,
      ST_PR_ORD,
      ST_PR_SRC,
      ST_PR_EVAL,
      ST_AN_ORD,
      ST_AN_SRC,
      ST_AN_EVAL,
      ST_AN_WR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [15:0] prio;
      logic [15:0] cool;
      logic [15:0] expiry;
      logic [31:0] trig;
      logic [31:0] nxt_frame;
   } src_word_type;

endpackage

[rtl/pas_ram.sv]
module pas_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/priority_announcement_scheduler_core.sv]
// Announcement scheduler for up to NUM_SOURCES sources.
// The req channel carries three kinds of items: load items define a source's
// priority, cooldown and expiry (only the first load of a source counts),
// request items raise a source's pending flag, and tick items run one frame.
// Load and request items produce no transfer on rsp.
// Every tick item produces exactly one rsp transfer with announce and
// announce_msg. With a player present a tick walks the sources to open
// entries; it then walks the open-order list to prune it and, with a player
// present and speech not busy, walks it again to pick the announcement, all
// through the source memory and the order memory, each with one read port.
// A tick with enable low or a frame below 2 skips the walks. The block
// takes one item at a time; req_stall is high while a tick runs.
// A finished result waits in the output register while rsp_stall is high,
// and load and request items are still taken meanwhile.
// The csr channel writes the enable bit and clears all pending requests; it
// is ready only while no tick runs.
// After reset enable is one and no source is defined, requested or open.
module priority_announcement_scheduler_core #(
   parameter int NUM_SOURCES = pas_pkg::NumSourcesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [5:0]  req_msg_index,
   input  logic [31:0] req_frame,
   input  logic        req_player_present,
   input  logic        req_low_power,
   input  logic        req_speech_busy,
   input  logic [15:0] req_priority_value,
   input  logic [15:0] req_cooldown_frames,
   input  logic [15:0] req_expiry_frames,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_announce,
   output logic [5:0]  rsp_announce_msg,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_enable
);

   localparam int IDX_W = $clog2(NUM_SOURCES);
   localparam int CNT_W = IDX_W + 1;
   localparam int WORD_W = $bits(pas_pkg::src_word_type);

   pas_pkg::state_type state_ff, state_in;
   logic                   enable_ff, enable_in;
   logic [NUM_SOURCES-1:0] reqf_ff, reqf_in;
   logic [NUM_SOURCES-1:0] def_ff, def_in;
   logic [NUM_SOURCES-1:0] open_ff, open_in;
   logic [NUM_SOURCES-1:0] played_ff, played_in;
   logic [31:0]            frame_ff, frame_in;
   logic                   player_ff, player_in;
   logic                   lowpow_ff, lowpow_in;
   logic                   busy_ff, busy_in;
   logic [CNT_W-1:0]       idx_ff, idx_in;
   logic [CNT_W-1:0]       keep_ff, keep_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [IDX_W-1:0]       ent_ff, ent_in;
   logic [15:0]            best_ff, best_in;
   logic                   found_ff, found_in;
   logic [IDX_W-1:0]       pick_ff, pick_in;
   pas_pkg::src_word_type  pword_ff, pword_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_ann_ff, rsp_ann_in;
   logic [5:0]             rsp_msg_ff, rsp_msg_in;

   logic                   src_we;
   logic [IDX_W-1:0]       src_waddr, src_raddr;
   pas_pkg::src_word_type  src_wdata, src_rdata;
   logic                   ord_we;
   logic [IDX_W-1:0]       ord_waddr, ord_raddr, ord_wdata, ord_rdata;

   logic                   req_xfer, csr_xfer, rsp_xfer, out_free;
   logic                   tick_live, load_ok, open_cond, drop, in_range;
   logic [IDX_W-1:0]       sidx, lidx;
   logic [CNT_W-1:0]       num_src;

   pas_ram #(.WIDTH(WORD_W), .DEPTH(NUM_SOURCES)) u_src_ram (
      .clock   (clock),
      .wr_en   (src_we),
      .wr_addr (src_waddr),
      .wr_data (src_wdata),
      .rd_addr (src_raddr),
      .rd_data (src_rdata)
   );

   pas_ram #(.WIDTH(IDX_W), .DEPTH(NUM_SOURCES)) u_ord_ram (
      .clock   (clock),
      .wr_en   (ord_we),
      .wr_addr (ord_waddr),
      .wr_data (ord_wdata),
      .rd_addr (ord_raddr),
      .rd_data (ord_rdata)
   );

   assign num_src   = CNT_W'(NUM_SOURCES);
   assign req_stall = (state_ff != pas_pkg::ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign csr_ready = (state_ff == pas_pkg::ST_IDLE);
   assign csr_xfer  = csr_valid && csr_ready;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign tick_live = enable_ff && (req_frame >= 32'd2);
   assign in_range  = ({1'b0, req_msg_index} < 7'(NUM_SOURCES));
   assign lidx      = req_msg_index[IDX_W-1:0];
   assign load_ok   = in_range && !def_ff[lidx];
   assign sidx      = idx_ff[IDX_W-1:0];
   assign open_cond = !open_ff[sidx] && def_ff[sidx]
                      && ((sidx == '0) ? lowpow_ff : reqf_ff[sidx]);
   assign drop      = played_ff[ent_ff]
                      ? (src_rdata.nxt_frame <= frame_ff + 32'd1)
                      : (src_rdata.trig + {16'd0, src_rdata.expiry} <= frame_ff);

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_announce     = rsp_ann_ff;
   assign rsp_announce_msg = rsp_msg_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pas_pkg::ST_IDLE: begin
            if (req_xfer && (req_func == pas_pkg::FUNC_TICK)) begin
               if (!tick_live) begin
                  state_in = pas_pkg::ST_DONE;
               end else if (req_player_present) begin
                  state_in = pas_pkg::ST_OPEN_CHK;
               end else begin
                  state_in = pas_pkg::ST_PR_ORD;
               end
            end
         end
         pas_pkg::ST_OPEN_CHK: begin
            if (idx_ff == num_src) begin
               state_in = pas_pkg::ST_PR_ORD;
            end else if (open_cond) begin
               state_in = pas_pkg::ST_OPEN_WR;
            end
         end
         pas_pkg::ST_OPEN_WR: state_in = pas_pkg::ST_OPEN_CHK;
         pas_pkg::ST_PR_ORD: begin
            if (idx_ff == count_ff) begin
               state_in = (player_ff && !busy_ff) ? pas_pkg::ST_AN_ORD : pas_pkg::ST_DONE;
            end else begin
               state_in = pas_pkg::ST_PR_SRC;
            end
         end
         pas_pkg::ST_PR_SRC:  state_in = pas_pkg::ST_PR_EVAL;
         pas_pkg::ST_PR_EVAL: state_in = pas_pkg::ST_PR_ORD;
         pas_pkg::ST_AN_ORD: begin
            state_in = (idx_ff == count_ff) ? pas_pkg::ST_AN_WR : pas_pkg::ST_AN_SRC;
         end
         pas_pkg::ST_AN_SRC:  state_in = pas_pkg::ST_AN_EVAL;
         pas_pkg::ST_AN_EVAL: state_in = pas_pkg::ST_AN_ORD;
         pas_pkg::ST_AN_WR:   state_in = pas_pkg::ST_DONE;
         pas_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = pas_pkg::ST_IDLE;
            end
         end
         default: state_in = pas_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      enable_in    = enable_ff;
      reqf_in      = reqf_ff;
      def_in       = def_ff;
      open_in      = open_ff;
      played_in    = played_ff;
      frame_in     = frame_ff;
      player_in    = player_ff;
      lowpow_in    = lowpow_ff;
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      keep_in      = keep_ff;
      count_in     = count_ff;
      ent_in       = ent_ff;
      best_in      = best_ff;
      found_in     = found_ff;
      pick_in      = pick_ff;
      pword_in     = pword_ff;
      rsp_valid_in = rsp_xfer ? 1'b0 : rsp_valid_ff;
      rsp_ann_in   = rsp_ann_ff;
      rsp_msg_in   = rsp_msg_ff;
      src_we       = 1'b0;
      src_waddr    = sidx;
      src_wdata    = src_rdata;
      src_raddr    = sidx;
      ord_we       = 1'b0;
      ord_waddr    = count_ff[IDX_W-1:0];
      ord_wdata    = sidx;
      ord_raddr    = sidx;

      unique case (state_ff)
         pas_pkg::ST_IDLE: begin
            if (req_xfer) begin
               unique case (req_func)
                  pas_pkg::FUNC_TICK: begin
                     frame_in  = req_frame;
                     player_in = req_player_present;
                     lowpow_in = req_low_power;
                     busy_in   = req_speech_busy;
                     idx_in    = '0;
                     keep_in   = '0;
                     best_in   = '0;
                     found_in  = 1'b0;
                     pick_in   = '0;
                  end
                  pas_pkg::FUNC_REQUEST: begin
                     if (in_range) begin
                        reqf_in[lidx] = 1'b1;
                     end
                  end
                  pas_pkg::FUNC_LOAD: begin
                     if (load_ok) begin
                        def_in[lidx]        = 1'b1;
                        src_we              = 1'b1;
                        src_waddr           = lidx;
                        src_wdata.prio      = req_priority_value;
                        src_wdata.cool      = req_cooldown_frames;
                        src_wdata.expiry    = req_expiry_frames;
                        src_wdata.trig      = '0;
                        src_wdata.nxt_frame = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            if (csr_xfer) begin
               enable_in = csr_enable;
               reqf_in   = '0;
            end
         end
         pas_pkg::ST_OPEN_CHK: begin
            src_raddr = sidx;
            if (idx_ff == num_src) begin
               idx_in = '0;
            end else if (!open_cond) begin
               idx_in = idx_ff + 1'b1;
            end
         end
         pas_pkg::ST_OPEN_WR: begin
            src_we              = 1'b1;
            src_waddr           = sidx;
            src_wdata           = src_rdata;
            src_wdata.trig      = frame_ff;
            src_wdata.nxt_frame = frame_ff + {16'd0, src_rdata.cool};
            ord_we              = 1'b1;
            ord_waddr           = count_ff[IDX_W-1:0];
            ord_wdata           = sidx;
            count_in            = count_ff + 1'b1;
            open_in[sidx]       = 1'b1;
            played_in[sidx]     = 1'b0;
            idx_in              = idx_ff + 1'b1;
         end
         pas_pkg::ST_PR_ORD: begin
            ord_raddr = sidx;
            if (idx_ff == count_ff) begin
               count_in = keep_ff;
               idx_in   = '0;
               reqf_in  = '0;
            end
         end
         pas_pkg::ST_PR_SRC: begin
            ent_in    = ord_rdata;
            src_raddr = ord_rdata;
         end
         pas_pkg::ST_PR_EVAL: begin
            if (drop) begin
               open_in[ent_ff]   = 1'b0;
               played_in[ent_ff] = 1'b0;
            end else begin
               ord_we    = 1'b1;
               ord_waddr = keep_ff[IDX_W-1:0];
               ord_wdata = ent_ff;
               keep_in   = keep_ff + 1'b1;
            end
            idx_in = idx_ff + 1'b1;
         end
         pas_pkg::ST_AN_ORD: begin
            ord_raddr = sidx;
         end
         pas_pkg::ST_AN_SRC: begin
            ent_in    = ord_rdata;
            src_raddr = ord_rdata;
         end
         pas_pkg::ST_AN_EVAL: begin
            if (!played_ff[ent_ff] && (src_rdata.prio > best_ff)) begin
               best_in  = src_rdata.prio;
               pick_in  = ent_ff;
               pword_in = src_rdata;
               found_in = 1'b1;
            end
            idx_in = idx_ff + 1'b1;
         end
         pas_pkg::ST_AN_WR: begin
            if (found_ff) begin
               src_we              = 1'b1;
               src_waddr           = pick_ff;
               src_wdata           = pword_ff;
               src_wdata.nxt_frame = frame_ff + {16'd0, pword_ff.cool};
               played_in[pick_ff]  = 1'b1;
            end
         end
         pas_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ann_in   = found_ff;
               rsp_msg_in   = found_ff ? 6'(pick_ff) : 6'd0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pas_pkg::ST_IDLE;
         enable_ff    <= 1'b1;
         reqf_ff      <= '0;
         def_ff       <= '0;
         open_ff      <= '0;
         played_ff    <= '0;
         idx_ff       <= '0;
         keep_ff      <= '0;
         count_ff     <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         enable_ff    <= enable_in;
         reqf_ff      <= reqf_in;
         def_ff       <= def_in;
         open_ff      <= open_in;
         played_ff    <= played_in;
         idx_ff       <= idx_in;
         keep_ff      <= keep_in;
         count_ff     <= count_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff   <= frame_in;
      player_ff  <= player_in;
      lowpow_ff  <= lowpow_in;
      busy_ff    <= busy_in;
      ent_ff     <= ent_in;
      best_ff    <= best_in;
      pick_ff    <= pick_in;
      pword_ff   <= pword_in;
      rsp_ann_ff <= rsp_ann_in;
      rsp_msg_ff <= rsp_msg_in;
   end

   // The open-order list holds exactly the open entries between ticks.
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pas_pkg::ST_IDLE) |-> ($countones(open_ff) == count_ff))
      else $error("open-order length differs from the number of open entries");

   a_played_open: assert property (@(posedge clock) disable iff (reset)
      (played_ff & ~open_ff) == '0)
      else $error("a closed entry is marked played");

   a_msg_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ann_ff) |-> (rsp_msg_ff == 6'd0))
      else $error("announce_msg is nonzero without an announcement");

   a_tick_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pas_pkg::ST_DONE && out_free) |=> rsp_valid_ff)
      else $error("finished tick did not present a transfer");

endmodule
